// ===== sv/tcpf_pkg.sv =====
// Shared types and constants for the triggered capture peak finder.
// No dependencies; imported by triggered_capture_peak_finder_core.
`default_nettype none

package tcpf_pkg;

  localparam int SMP_W = 12;   // converter sample width
  localparam int MV_W  = 12;   // millivolt result width
  localparam int PIDX_W = 8;   // reported peak position width

  // operation codes
  localparam logic [1:0] OP_SAMPLE  = 2'd0;
  localparam logic [1:0] OP_TRIGGER = 2'd1;
  localparam logic [1:0] OP_REARM   = 2'd2;

  // millivolt scaling: mv = sample * VREF_MV / FULL_SCALE
  localparam logic [SMP_W-1:0] VREF_MV    = 12'd3300;
  localparam logic [SMP_W-1:0] FULL_SCALE = 12'd4095;

  typedef struct packed {
    logic [1:0]       operation;
    logic             channel;
    logic [SMP_W-1:0] sample;
  } item_t;

  typedef struct packed {
    logic              channel_out;
    logic [PIDX_W-1:0] peak_index;
    logic [SMP_W-1:0]  peak_sample;
    logic [MV_W-1:0]   peak_mv;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/triggered_capture_peak_finder_core.sv =====
// Triggered capture peak finder: per-channel sample rings in one memory,
// window peak scan on trigger, millivolt conversion. Depends on tcpf_pkg.
`default_nettype none

// Each channel keeps a ring of RING_DEPTH 12-bit samples, all held in one
// single-port synchronous memory addressed by {channel, ring position}.
// Sample and rearm beats are taken one per cycle while item_stall is low. A
// trigger beat stops capture on its channel and scans the window around the
// write position: one memory read per cycle (centre first, then the window
// in order), and item_stall stays high through the scan and the drain,
// multiply, estimate and divide states. The window covers SPAN positions,
// where SPAN is min(2*(SEARCH_WINDOW/2)+1, RING_DEPTH). The single read port
// of the sample memory sets the scan rate. The result sits in an output
// register, so the next beat is taken while the peak beat still waits on
// peak_stall; a following trigger only waits at its final step for that
// register to empty. Memory contents are not cleared at reset: a per-channel
// fill count records how far each ring has been written since reset (writes
// always run upwards from position 0), and positions beyond it read as zero.
// There is therefore no clearing pass. Beats whose channel is not below
// CHANNEL_COUNT, and operation code 3, are taken and dropped.
module triggered_capture_peak_finder_core
  import tcpf_pkg::*;
#(
  parameter int RING_DEPTH    = 256,
  parameter int SEARCH_WINDOW = 64,
  parameter int CHANNEL_COUNT = 2
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    peak_valid,
  input  logic    peak_stall,
  output result_t peak
);

  localparam int IW        = $clog2(RING_DEPTH);
  localparam int CW        = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam int MEM_DEPTH = CHANNEL_COUNT * (2 ** IW);
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam int HALF      = SEARCH_WINDOW / 2;
  localparam int HALF_MOD  = HALF % RING_DEPTH;
  localparam int SPAN      = (2 * HALF + 1 > RING_DEPTH) ? RING_DEPTH : 2 * HALF + 1;
  localparam int SW        = $clog2(SPAN + 1);
  localparam int PW        = 2 * SMP_W;        // product width
  localparam int EW        = SMP_W + 1;        // quotient estimate width

  localparam logic [IW:0]   RD_X   = (IW + 1)'(RING_DEPTH);
  localparam logic [IW:0]   HALF_X = (IW + 1)'(HALF_MOD);
  localparam logic [IW-1:0] LAST   = IW'(RING_DEPTH - 1);
  localparam logic [SW-1:0] SPAN_S = SW'(SPAN);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_DRAIN = 6'b000100,
    S_MUL   = 6'b001000,
    S_EST   = 6'b010000,
    S_DIV   = 6'b100000
  } state_t;

  state_t state;

  // per-channel control
  logic [IW-1:0] write_index [CHANNEL_COUNT];
  logic          stopped     [CHANNEL_COUNT];
  logic [IW:0]   fill        [CHANNEL_COUNT];

  // sample memory
  logic [SMP_W-1:0] mem [MEM_DEPTH];

  // scan context
  logic          ch_q;
  logic [CW-1:0] ch_idx_q;
  logic [IW-1:0] scan_pos;
  logic [IW-1:0] scan_start;
  logic [IW:0]   fill_q;
  logic [SW-1:0] step;

  // read pipeline
  logic             rd_vld;
  logic             rd_first;
  logic             rd_ok;
  logic [IW-1:0]    rd_pos;
  logic [SMP_W-1:0] rd_data;

  // running peak and conversion
  logic [SMP_W-1:0] best_val;
  logic [IW-1:0]    best_pos;
  logic [PW-1:0]    prod;
  logic [EW-1:0]    est;

  logic             accept;
  logic             ch_ok;
  logic [CW-1:0]    ch_idx;
  logic [IW-1:0]    w_cur;
  logic [IW:0]      centre_x;
  logic [IW:0]      start_x;
  logic             do_write;
  logic [AW-1:0]    wr_addr;
  logic [AW-1:0]    rd_addr;
  logic [SMP_W-1:0] cand;
  logic             load_out;
  logic [PW:0]      est_sum;
  logic [PW:0]      est_mul;
  logic [PW:0]      rem;
  logic [EW-1:0]    quot;

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign ch_ok      = (CHANNEL_COUNT > 1) || !item.channel;
  assign ch_idx     = CW'(item.channel);
  assign w_cur      = write_index[ch_idx];

  // window start = centre - half, wrapped into the ring
  assign centre_x = {1'b0, w_cur};
  assign start_x  = (centre_x >= HALF_X) ? (centre_x - HALF_X)
                                         : (centre_x + RD_X - HALF_X);

  assign do_write = accept && ch_ok && (item.operation == OP_SAMPLE) && !stopped[ch_idx];
  assign wr_addr  = AW'({ch_idx, w_cur});
  assign rd_addr  = AW'({ch_idx_q, scan_pos});

  // never-written positions read as zero
  assign cand = rd_ok ? rd_data : '0;

  // x / 4095 for x < 2^24: estimate x*(1 + 2^-12)/2^12 is never high and at
  // most one low, so one compare of the remainder finishes it
  assign est_sum = (PW + 1)'(prod) + (PW + 1)'(prod >> SMP_W);
  assign est_mul = ((PW + 1)'(est) << SMP_W) - (PW + 1)'(est);
  assign rem     = (PW + 1)'(prod) - est_mul;
  assign quot    = (rem >= (PW + 1)'(FULL_SCALE)) ? est + EW'(1) : est;

  assign load_out = (state == S_DIV) && (!peak_valid || !peak_stall);

  // sequencer and per-channel control
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      rd_vld <= 1'b0;
      for (int c = 0; c < CHANNEL_COUNT; c++) begin
        write_index[c] <= '0;
        stopped[c]     <= 1'b1;
        fill[c]        <= '0;
      end
    end else begin
      rd_vld <= (state == S_SCAN);
      unique case (state)
        S_IDLE: begin
          if (accept && ch_ok) begin
            priority case (item.operation)
              OP_SAMPLE: begin
                if (!stopped[ch_idx]) begin
                  write_index[ch_idx] <= (w_cur == LAST) ? '0 : w_cur + IW'(1);
                  if ({1'b0, w_cur} >= fill[ch_idx]) begin
                    fill[ch_idx] <= {1'b0, w_cur} + (IW + 1)'(1);
                  end
                end
              end
              OP_REARM: begin
                write_index[ch_idx] <= '0;
                stopped[ch_idx]     <= 1'b0;
              end
              OP_TRIGGER: begin
                stopped[ch_idx] <= 1'b1;
                state           <= S_SCAN;
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          if (step == SPAN_S) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: state <= S_MUL;
        S_MUL:   state <= S_EST;
        S_EST:   state <= S_DIV;
        S_DIV: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // scan context; centre read first, then the window in order
  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      ch_q       <= item.channel;
      ch_idx_q   <= ch_idx;
      scan_pos   <= w_cur;
      scan_start <= start_x[IW-1:0];
      fill_q     <= fill[ch_idx];
      step       <= '0;
    end else if (state == S_SCAN) begin
      step     <= step + SW'(1);
      scan_pos <= (step == '0) ? scan_start
                : (scan_pos == LAST) ? '0 : scan_pos + IW'(1);
    end
  end

  // sample memory, one write or one read per cycle
  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[wr_addr] <= item.sample;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_SCAN) begin
      rd_data  <= mem[rd_addr];
      rd_pos   <= scan_pos;
      rd_first <= (step == '0);
      rd_ok    <= ({1'b0, scan_pos} < fill_q);
    end
  end

  // running peak: centre seeds it, later beats need a strictly greater value
  always_ff @(posedge clk) begin
    if (rd_vld && (rd_first || cand > best_val)) begin
      best_val <= cand;
      best_pos <= rd_pos;
    end
  end

  // conversion and result register
  always_ff @(posedge clk) begin
    if (state == S_MUL) begin
      prod <= PW'(best_val) * PW'(VREF_MV);
    end
    if (state == S_EST) begin
      est <= EW'(est_sum >> SMP_W);
    end
    if (load_out) begin
      peak.channel_out <= ch_q;
      peak.peak_index  <= PIDX_W'(best_pos);
      peak.peak_sample <= best_val;
      peak.peak_mv     <= MV_W'(quot);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_valid <= 1'b0;
    end else if (load_out) begin
      peak_valid <= 1'b1;
    end else if (peak_valid && !peak_stall) begin
      peak_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire
